// File: hw/rtl/xts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and AES/GF(2^128) helper functions for the XTS sector unit.
package xts_pkg;

   localparam int unsigned NUM_ROUNDS = 14;
   localparam int unsigned NUM_RKEYS = NUM_ROUNDS + 1;
   localparam logic [7:0] MAX_BLOCK_INDEX = 8'd255;
   localparam logic [7:0] GF_FOLD = 8'h87;

   localparam logic [2:0] CSR_DATA_KEY_W0 = 3'd0;
   localparam logic [2:0] CSR_DATA_KEY_W1 = 3'd1;
   localparam logic [2:0] CSR_DATA_KEY_W2 = 3'd2;
   localparam logic [2:0] CSR_DATA_KEY_W3 = 3'd3;
   localparam logic [2:0] CSR_TWEAK_KEY_W0 = 3'd4;
   localparam logic [2:0] CSR_TWEAK_KEY_W1 = 3'd5;
   localparam logic [2:0] CSR_TWEAK_KEY_W2 = 3'd6;
   localparam logic [2:0] CSR_TWEAK_KEY_W3 = 3'd7;

   typedef logic [7:0] sbox_table_type [256];

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_KEXP,
      OP_TLOAD,
      OP_EROUND,
      OP_DROUND,
      OP_BASE,
      OP_TSEL,
      OP_DOUBLE,
      OP_DLOAD,
      OP_OUT
   } xts_op_type;

   localparam logic KEY_DATA = 1'b0;
   localparam logic KEY_TWEAK = 1'b1;

   typedef struct packed {
      xts_op_type op;
      logic [3:0] rnd;
      logic       key_sel;
   } xts_cmd_type;

   typedef struct packed {
      logic       new_sector;
      logic       action;
      logic       restart;
      logic [7:0] idx;
      logic       out_free;
   } xts_status_type;

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic sbox_table_type build_inv_sbox();
      sbox_table_type inv;
      for (int i = 0; i < 256; i++) begin
         inv[SBOX[i]] = 8'(i);
      end
      return inv;
   endfunction

   localparam sbox_table_type INV_SBOX = build_inv_sbox();

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      logic [31:0] r;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = SBOX[w[8*i +: 8]];
      end
      return r;
   endfunction

   function automatic logic [127:0] shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)&3)+r) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(4*((c+r)&3)+r) +: 8] = INV_SBOX[s[8*(4*c+r) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] t);
      logic [127:0] s;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(4*c)   +: 8];
         a1 = t[8*(4*c+1) +: 8];
         a2 = t[8*(4*c+2) +: 8];
         a3 = t[8*(4*c+3) +: 8];
         s[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         s[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         s[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         s[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return s;
   endfunction

   function automatic logic [127:0] inv_mix_columns(input logic [127:0] t);
      logic [127:0] s;
      logic [7:0] a [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      logic [7:0] x2, x4, x8;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k] = t[8*(4*c+k) +: 8];
            x2 = xtime(a[k]);
            x4 = xtime(x2);
            x8 = xtime(x4);
            m9[k] = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
         end
         s[8*(4*c)   +: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
         s[8*(4*c+1) +: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
         s[8*(4*c+2) +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
         s[8*(4*c+3) +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      end
      return s;
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] t);
      logic [127:0] r;
      r = {t[126:0], 1'b0};
      r[7:0] = r[7:0] ^ (t[127] ? GF_FOLD : 8'h00);
      return r;
   endfunction

endpackage

// File: hw/rtl/xts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the XTS sector unit: key expansion, tweak and data cipher passes.
module xts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  xts_pkg::xts_status_type status,
   output xts_pkg::xts_cmd_type    cmd
);
   import xts_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_TKEXP,
      S_TLOAD,
      S_TROUND,
      S_TBASE,
      S_TSEL,
      S_DOUBLE,
      S_DKEXP,
      S_DLOAD,
      S_DROUND,
      S_DONE
   } state_type;

   state_type state_ff;
   logic [7:0] cnt_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.op = OP_NONE;
      cmd.rnd = cnt_ff[3:0];
      cmd.key_sel = KEY_DATA;
      unique case (state_ff)
         S_IDLE:   if (req_valid) cmd.op = OP_LATCH;
         S_START:  cmd.op = OP_NONE;
         S_TKEXP: begin
            cmd.op = OP_KEXP;
            cmd.key_sel = KEY_TWEAK;
         end
         S_TLOAD:  cmd.op = OP_TLOAD;
         S_TROUND: cmd.op = OP_EROUND;
         S_TBASE:  cmd.op = OP_BASE;
         S_TSEL:   cmd.op = OP_TSEL;
         S_DOUBLE: cmd.op = OP_DOUBLE;
         S_DKEXP:  cmd.op = OP_KEXP;
         S_DLOAD:  cmd.op = OP_DLOAD;
         S_DROUND: cmd.op = status.action ? OP_DROUND : OP_EROUND;
         S_DONE:   if (status.out_free) cmd.op = OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_START;
            S_START: begin
               cnt_ff <= '0;
               state_ff <= status.new_sector ? S_TKEXP : S_TSEL;
            end
            S_TKEXP: begin
               if (cnt_ff == 8'(NUM_ROUNDS)) begin
                  state_ff <= S_TLOAD;
               end else begin
                  cnt_ff <= cnt_ff + 8'd1;
               end
            end
            S_TLOAD: begin
               cnt_ff <= 8'd1;
               state_ff <= S_TROUND;
            end
            S_TROUND: begin
               if (cnt_ff == 8'(NUM_ROUNDS)) begin
                  state_ff <= S_TBASE;
               end else begin
                  cnt_ff <= cnt_ff + 8'd1;
               end
            end
            S_TBASE: state_ff <= S_TSEL;
            S_TSEL: begin
               if (status.restart && (status.idx != 8'd0)) begin
                  cnt_ff <= status.idx;
                  state_ff <= S_DOUBLE;
               end else begin
                  cnt_ff <= '0;
                  state_ff <= S_DKEXP;
               end
            end
            S_DOUBLE: begin
               if (cnt_ff == 8'd1) begin
                  cnt_ff <= '0;
                  state_ff <= S_DKEXP;
               end else begin
                  cnt_ff <= cnt_ff - 8'd1;
               end
            end
            S_DKEXP: begin
               if (cnt_ff == 8'(NUM_ROUNDS)) begin
                  state_ff <= S_DLOAD;
               end else begin
                  cnt_ff <= cnt_ff + 8'd1;
               end
            end
            S_DLOAD: begin
               cnt_ff <= status.action ? 8'(NUM_ROUNDS - 1) : 8'd1;
               state_ff <= S_DROUND;
            end
            S_DROUND: begin
               if (status.action) begin
                  if (cnt_ff == 8'd0) begin
                     state_ff <= S_DONE;
                  end else begin
                     cnt_ff <= cnt_ff - 8'd1;
                  end
               end else begin
                  if (cnt_ff == 8'(NUM_ROUNDS)) begin
                     state_ff <= S_DONE;
                  end else begin
                     cnt_ff <= cnt_ff + 8'd1;
                  end
               end
            end
            S_DONE: if (status.out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/xts_dpath.sv
`timescale 1ns / 1ps
// Datapath of the XTS sector unit: key registers, round keys, AES round, tweak and output.
module xts_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [63:0]             csr_wdata,
   input  logic                    req_action,
   input  logic                    req_new_sector,
   input  logic [63:0]             req_sector,
   input  logic [7:0]              req_block_index,
   input  logic [63:0]             req_data_lo,
   input  logic [63:0]             req_data_hi,
   input  xts_pkg::xts_cmd_type    cmd,
   output xts_pkg::xts_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [63:0]             rsp_out_lo,
   output logic [63:0]             rsp_out_hi
);
   import xts_pkg::*;

   logic [63:0]  key_ff [8];
   logic [127:0] rk_ff [NUM_RKEYS];
   logic [255:0] win_ff;
   logic [127:0] state_ff;
   logic [127:0] base_ff;
   logic [127:0] tweak_ff;
   logic [7:0]   cur_idx_ff;
   logic         tweak_valid_ff;
   logic         action_ff;
   logic         new_sector_ff;
   logic [63:0]  sector_ff;
   logic [7:0]   idx_ff;
   logic [127:0] data_ff;
   logic         rsp_valid_ff;
   logic [127:0] out_ff;

   logic [255:0] key_sel_in;
   logic [127:0] rk_next_in;
   logic [31:0]  kt_in;
   logic [7:0]   rcon_in;
   logic [127:0] rk_rd;
   logic [127:0] enc_round_in;
   logic [127:0] dec_round_in;
   logic         is_next_in;
   logic         is_same_in;

   assign key_sel_in = (cmd.key_sel == KEY_TWEAK)
                     ? {key_ff[7], key_ff[6], key_ff[5], key_ff[4]}
                     : {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   assign rcon_in = 8'h01 << (cmd.rnd[3:1] - 3'd1);

   always_comb begin
      if (cmd.rnd[0] == 1'b0) begin
         kt_in = sub_word({win_ff[231:224], win_ff[255:232]}) ^ {24'h0, rcon_in};
      end else begin
         kt_in = sub_word(win_ff[255:224]);
      end
      rk_next_in[31:0]   = win_ff[31:0]   ^ kt_in;
      rk_next_in[63:32]  = win_ff[63:32]  ^ rk_next_in[31:0];
      rk_next_in[95:64]  = win_ff[95:64]  ^ rk_next_in[63:32];
      rk_next_in[127:96] = win_ff[127:96] ^ rk_next_in[95:64];
   end

   assign rk_rd = rk_ff[cmd.rnd];

   always_comb begin
      if (cmd.rnd == 4'(NUM_ROUNDS)) begin
         enc_round_in = shift_sub(state_ff) ^ rk_rd;
      end else begin
         enc_round_in = mix_columns(shift_sub(state_ff)) ^ rk_rd;
      end
      if (cmd.rnd == 4'd0) begin
         dec_round_in = inv_shift_sub(state_ff) ^ rk_rd;
      end else begin
         dec_round_in = inv_mix_columns(inv_shift_sub(state_ff) ^ rk_rd);
      end
   end

   assign is_next_in = tweak_valid_ff && ({1'b0, idx_ff} == ({1'b0, cur_idx_ff} + 9'd1));
   assign is_same_in = tweak_valid_ff && (idx_ff == cur_idx_ff);

   assign status.new_sector = new_sector_ff;
   assign status.action = action_ff;
   assign status.restart = !is_next_in && !is_same_in;
   assign status.idx = idx_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_lo = out_ff[63:0];
   assign rsp_out_hi = out_ff[127:64];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            key_ff[i] <= '0;
         end
         base_ff <= '0;
         tweak_ff <= '0;
         cur_idx_ff <= '0;
         tweak_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            key_ff[csr_index] <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_NONE: ;
            OP_LATCH: begin
               action_ff <= req_action;
               new_sector_ff <= req_new_sector;
               sector_ff <= req_sector;
               idx_ff <= (req_block_index > MAX_BLOCK_INDEX) ? MAX_BLOCK_INDEX
                                                              : req_block_index;
               data_ff <= {req_data_hi, req_data_lo};
            end
            OP_KEXP: begin
               if (cmd.rnd == 4'd0) begin
                  rk_ff[cmd.rnd] <= key_sel_in[127:0];
               end else if (cmd.rnd == 4'd1) begin
                  rk_ff[cmd.rnd] <= key_sel_in[255:128];
                  win_ff <= key_sel_in;
               end else begin
                  rk_ff[cmd.rnd] <= rk_next_in;
                  win_ff <= {rk_next_in, win_ff[255:128]};
               end
            end
            OP_TLOAD: state_ff <= {64'h0, sector_ff} ^ rk_ff[0];
            OP_EROUND: state_ff <= enc_round_in;
            OP_DROUND: state_ff <= dec_round_in;
            OP_BASE: begin
               base_ff <= state_ff;
               tweak_valid_ff <= 1'b0;
            end
            OP_TSEL: begin
               if (is_next_in) begin
                  tweak_ff <= gf_double(tweak_ff);
               end else if (!is_same_in) begin
                  tweak_ff <= base_ff;
               end
               cur_idx_ff <= idx_ff;
               tweak_valid_ff <= 1'b1;
            end
            OP_DOUBLE: tweak_ff <= gf_double(tweak_ff);
            OP_DLOAD: begin
               if (action_ff) begin
                  state_ff <= data_ff ^ tweak_ff ^ rk_ff[NUM_ROUNDS];
               end else begin
                  state_ff <= data_ff ^ tweak_ff ^ rk_ff[0];
               end
            end
            OP_OUT: begin
               out_ff <= state_ff ^ tweak_ff;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule

// File: hw/rtl/xts_aes256_sector_crypt.sv
`timescale 1ns / 1ps
// Top level of the XTS-AES-256 sector unit (no ciphertext stealing).
//
// Usage:
//  - Load the data key (csr_index 0..3) and tweak key (4..7) through the csr_
//    write port while the unit is idle; writes take effect on the next cycle.
//  - Present one 16-byte block per req_ transfer. With req_new_sector set the
//    base tweak is first rebuilt by encrypting req_sector under the tweak key.
//  - One rsp_ transfer carries the result block of each request, in order.
// Tweak handling per request:
//  - the tweak is reused or advanced by one doubling,
//  - or it restarts from the base tweak and is doubled block_index times,
//  - and a new sector first adds tweak key expansion and encryption.
// The unit handles one block at a time; each block runs a full round key
// expansion and an iterative AES round loop on a single round unit.
// A new request is taken while the previous result still waits in the output
// register. If the receiver stalls, the finished block waits until the output
// register frees up. Reset clears keys, tweak state and both handshakes.
module xts_aes256_sector_crypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic        req_new_sector,
   input  logic [63:0] req_sector,
   input  logic [7:0]  req_block_index,
   input  logic [63:0] req_data_lo,
   input  logic [63:0] req_data_hi,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_lo,
   output logic [63:0] rsp_out_hi
);
   import xts_pkg::*;

   xts_cmd_type    cmd;
   xts_status_type status;

   xts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   xts_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_new_sector  (req_new_sector),
      .req_sector      (req_sector),
      .req_block_index (req_block_index),
      .req_data_lo     (req_data_lo),
      .req_data_hi     (req_data_hi),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_lo      (rsp_out_lo),
      .rsp_out_hi      (rsp_out_hi)
   );

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another block is in flight");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.op == OP_OUT))
      else $error("response raised without an output command");

   a_out_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten before transfer");
`endif

endmodule
